@@ sv/ellspmv_pkg.sv @@
`timescale 1ns / 1ps
package ellspmv_pkg;

    localparam int VEC_DEPTH = 4096;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_VEC_LEN   = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SLOT = 1'b1;

    typedef struct packed {
        logic load_acc;
        logic slot_acc;
        logic mul_en;
        logic acc_en;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic contrib;
        logic row_end;
        logic out_busy;
    } t_dp_sts;

endpackage

@@ sv/ellspmv_ctrl.sv @@
`timescale 1ns / 1ps
module ellspmv_ctrl
    import ellspmv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_command,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_command == CMD_SLOT) begin
                        o_cmd.slot_acc = 1'b1;
                        n_state = i_sts.contrib ? ST_MUL : ST_FIN;
                    end else begin
                        o_cmd.load_acc = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!(i_sts.row_end && i_sts.out_busy)) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/ellspmv_dp.sv @@
`timescale 1ns / 1ps
module ellspmv_dp
    import ellspmv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic [11:0]         i_vec_index,
    input  logic signed [31:0]  i_vec_value,
    input  logic [15:0]         i_col_index,
    input  logic signed [31:0]  i_entry_value,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_row_index,
    output logic signed [31:0]  o_row_sum,
    output logic                o_nonzero,
    output logic                o_last_row
);

    logic [15:0] r_row_width;
    logic [15:0] r_row_count;
    logic [12:0] r_vec_len;

    logic signed [31:0] r_mem [VEC_DEPTH];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_entry;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic [12:0]        r_pos;
    logic [15:0]        r_slot;
    logic [15:0]        r_row;
    logic               r_out_valid;

    logic [16:0]        w_len17;
    logic [12:0]        w_len;
    logic               w_past_len;
    logic               w_wr_ok;
    logic [64:0]        w_sum;
    logic signed [63:0] w_acc_sat;
    logic [64:0]        w_rnd;
    logic [48:0]        w_q;
    logic signed [31:0] w_q16;
    logic               w_last;

    // effective vector length, capped at the store depth
    assign w_len17    = (17'(r_vec_len) > 17'(VEC_DEPTH)) ? 17'(VEC_DEPTH) : 17'(r_vec_len);
    assign w_len      = w_len17[12:0];
    assign w_past_len = ({1'b0, i_col_index} >= 17'(w_len));
    assign w_wr_ok    = (17'(i_vec_index) < 17'(VEC_DEPTH));

    assign o_sts.contrib  = !w_past_len && ({1'b0, i_col_index} >= 17'(r_pos));
    assign o_sts.row_end  = ({1'b0, r_slot} + 17'd1) >= {1'b0, r_row_width};
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // saturating accumulate
    assign w_sum = {r_acc[63], r_acc} + {r_prod[63], r_prod};
    always_comb begin
        if (w_sum[64] != w_sum[63]) begin
            w_acc_sat = w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_acc_sat = w_sum[63:0];
        end
    end

    // q32.32 to q16.16, round half up, saturate
    assign w_rnd = {r_acc[63], r_acc} + 65'd32768;
    assign w_q   = w_rnd[64:16];
    always_comb begin
        if (w_q[48:31] != {18{w_q[48]}}) begin
            w_q16 = w_q[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_q16 = w_q[31:0];
        end
    end

    assign w_last = ({1'b0, r_row} + 17'd1) >= {1'b0, r_row_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_acc && w_wr_ok) begin
            r_mem[VEC_AW'(i_vec_index)] <= i_vec_value;
        end
        if (i_cmd.slot_acc) begin
            r_rdata <= r_mem[i_col_index[VEC_AW-1:0]];
            r_entry <= i_entry_value;
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_entry * r_rdata;
        end
        if (i_cmd.finish && o_sts.row_end) begin
            o_row_index <= r_row;
            o_row_sum   <= w_q16;
            o_nonzero   <= (w_q16 != 32'sd0);
            o_last_row  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= 16'd1;
            r_row_count <= 16'd1;
            r_vec_len   <= 13'd0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_slot      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROW_WIDTH: r_row_width <= i_cfg_data;
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    CFG_VEC_LEN:   r_vec_len   <= i_cfg_data[12:0];
                    default: ;
                endcase
            end

            if (i_cmd.slot_acc) begin
                if (w_past_len) begin
                    if (r_pos < w_len) begin
                        r_pos <= w_len;
                    end
                end else if (o_sts.contrib) begin
                    r_pos <= 13'(i_col_index) + 13'd1;
                end
            end

            if (i_cmd.acc_en) begin
                r_acc <= w_acc_sat;
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.finish) begin
                if (o_sts.row_end) begin
                    r_out_valid <= 1'b1;
                    r_slot      <= '0;
                    r_acc       <= '0;
                    r_pos       <= '0;
                    r_row       <= w_last ? 16'd0 : r_row + 16'd1;
                end else begin
                    r_slot <= r_slot + 16'd1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/ellpack_spmv_row_accumulator_unit.sv @@
`timescale 1ns / 1ps
// load transfer: taken in the idle state; matrix slot: finish step only, or multiply,
// accumulate and finish steps when it gathers a vector entry (gather from the single-port
// vector store, 32x32 multiply, 64-bit saturating add); row result is registered on the
// output as the row's last slot leaves the finish step, which waits while the previous
// result is still unread; synchronous active-low reset clears counters, accumulator, vector
// length and output valid, sets row width and row count to 1; the vector store is not cleared
module ellpack_spmv_row_accumulator_unit
    import ellspmv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [11:0]         i_vec_index,
    input  logic signed [31:0]  i_vec_value,
    input  logic [15:0]         i_col_index,
    input  logic signed [31:0]  i_entry_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_row_index,
    output logic signed [31:0]  o_row_sum,
    output logic                o_nonzero,
    output logic                o_last_row
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ellspmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ellspmv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_vec_index   (i_vec_index),
        .i_vec_value   (i_vec_value),
        .i_col_index   (i_col_index),
        .i_entry_value (i_entry_value),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_index   (o_row_index),
        .o_row_sum     (o_row_sum),
        .o_nonzero     (o_nonzero),
        .o_last_row    (o_last_row)
    );

endmodule

@@ tb/sv/ellpack_spmv_row_checker.sv @@
`timescale 1ns / 1ps
module ellpack_spmv_row_checker
    import ellspmv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_command,
    input  logic [11:0]        i_vec_index,
    input  logic signed [31:0] i_vec_value,
    input  logic [15:0]        i_col_index,
    input  logic signed [31:0] i_entry_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [15:0]        i_row_index,
    input  logic signed [31:0] i_row_sum,
    input  logic               i_nonzero,
    input  logic               i_last_row,
    output int                 o_fail_count,
    output int                 o_rows_pending
);

    typedef struct {
        logic [15:0]        row;
        logic signed [31:0] sum;
        logic               nonzero;
        logic               last;
    } t_row_result;

    logic signed [31:0] vec_mem [VEC_DEPTH];
    logic signed [63:0] acc_q32;
    logic [12:0]        walk_pos;
    logic [15:0]        slot_cnt;
    logic [15:0]        row_cnt;
    logic [15:0]        row_width;
    logic [15:0]        row_count;
    logic [12:0]        vec_len;
    t_row_result        expected_rows[$];
    int                 fails = 0;

    task automatic report(input string what, input longint got, input longint want);
        fails++;
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // q32.32 to q16.16, round half up, then clamp
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] a);
        logic signed [65:0] t;
        logic signed [65:0] q;
        t = a;
        t = t + 66'sd32768;
        q = t >>> 16;
        if (q > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (q < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return q[31:0];
    endfunction

    task automatic take_slot(input logic [15:0] col, input logic signed [31:0] val);
        logic [12:0]        len;
        logic signed [63:0] prod;
        logic signed [31:0] sum;
        t_row_result        r;
        len = (vec_len > 13'(VEC_DEPTH)) ? 13'(VEC_DEPTH) : vec_len;
        if (col >= len) begin
            if (walk_pos < len) begin
                walk_pos = len;
            end
        end else if (col >= walk_pos) begin
            prod     = val * vec_mem[col[11:0]];
            acc_q32  = add_sat(acc_q32, prod);
            walk_pos = col[12:0] + 13'd1;
        end
        if (int'(slot_cnt) + 1 < int'(row_width)) begin
            slot_cnt = slot_cnt + 16'd1;
        end else begin
            sum       = round_sat(acc_q32);
            r.row     = row_cnt;
            r.sum     = sum;
            r.nonzero = (sum != 0);
            r.last    = (int'(row_cnt) + 1 >= int'(row_count));
            expected_rows.push_back(r);
            row_cnt  = r.last ? 16'd0 : row_cnt + 16'd1;
            slot_cnt = 16'd0;
            acc_q32  = 64'sd0;
            walk_pos = 13'd0;
        end
    endtask

    task automatic check_row();
        t_row_result want;
        if (expected_rows.size() == 0) begin
            report("unexpected row transfer, row_index", i_row_index, -1);
        end else begin
            want = expected_rows.pop_front();
            if (i_row_index !== want.row) begin
                report("row_index", i_row_index, want.row);
            end
            if (i_row_sum !== want.sum) begin
                report("row_sum", i_row_sum, want.sum);
            end
            if (i_nonzero !== want.nonzero) begin
                report("nonzero", i_nonzero, want.nonzero);
            end
            if (i_last_row !== want.last) begin
                report("last_row", i_last_row, want.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_q32   = 64'sd0;
            walk_pos  = 13'd0;
            slot_cnt  = 16'd0;
            row_cnt   = 16'd0;
            row_width = 16'd1;
            row_count = 16'd1;
            vec_len   = 13'd0;
            expected_rows.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_row();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_WIDTH: row_width = i_cfg_data;
                    CFG_ROW_COUNT: row_count = i_cfg_data;
                    CFG_VEC_LEN:   vec_len   = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_LOAD) begin
                    vec_mem[i_vec_index] = i_vec_value;
                end else begin
                    take_slot(i_col_index, i_entry_value);
                end
            end
        end
        o_fail_count   <= fails;
        o_rows_pending <= expected_rows.size();
    end

endmodule

@@ tb/sv/tb_ellpack_spmv_row_accumulator_unit.sv @@
`timescale 1ns / 1ps
module tb_ellpack_spmv_row_accumulator_unit;
    import ellspmv_pkg::*;

    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IW-1:0]  i_cfg_index;
    logic [CFG_DW-1:0]  i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_command;
    logic [11:0]        i_vec_index;
    logic signed [31:0] i_vec_value;
    logic [15:0]        i_col_index;
    logic signed [31:0] i_entry_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [15:0]        o_row_index;
    logic signed [31:0] o_row_sum;
    logic               o_nonzero;
    logic               o_last_row;

    int fail_count;
    int rows_pending;
    int send_idle;
    int recv_idle;
    int hold_req;
    int hold_left;
    int n_items;
    int cur_rw;
    int cur_len;
    bit loaded [VEC_DEPTH];
    int loaded_list[$];

    ellpack_spmv_row_accumulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_vec_index   (i_vec_index),
        .i_vec_value   (i_vec_value),
        .i_col_index   (i_col_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_index   (o_row_index),
        .o_row_sum     (o_row_sum),
        .o_nonzero     (o_nonzero),
        .o_last_row    (o_last_row)
    );

    ellpack_spmv_row_checker u_row_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_vec_index    (i_vec_index),
        .i_vec_value    (i_vec_value),
        .i_col_index    (i_col_index),
        .i_entry_value  (i_entry_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_row_index    (o_row_index),
        .i_row_sum      (o_row_sum),
        .i_nonzero      (o_nonzero),
        .i_last_row     (o_last_row),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // result side, with a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            3, 4: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int first_loaded(input int from);
        for (int i = from; i < cur_len; i++) begin
            if (loaded[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    // any column whose gather stays within written entries
    function automatic logic [15:0] any_col();
        int r;
        r = $urandom_range(0, 65535);
        if (r < cur_len && !loaded[r]) begin
            r = (loaded_list.size() != 0) ?
                loaded_list[$urandom_range(0, loaded_list.size() - 1)] : cur_len;
        end
        return 16'(r);
    endfunction

    task automatic put_item(input logic cmd, input logic [11:0] vi, input logic [31:0] vv,
                            input logic [15:0] ci, input logic [31:0] ev);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_vec_index   <= vi;
        i_vec_value   <= vv;
        i_col_index   <= ci;
        i_entry_value <= ev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic load_entry(input int idx, input logic [31:0] val);
        put_item(CMD_LOAD, 12'(idx), val, 16'($urandom), $urandom);
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    task automatic send_slot(input logic [15:0] col, input logic [31:0] val);
        put_item(CMD_SLOT, 12'($urandom), $urandom, col, val);
    endtask

    task automatic write_regs(input logic [15:0] rw, input logic [15:0] rc,
                              input logic [15:0] vl);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROW_WIDTH;
        i_cfg_data  <= rw;
        @(negedge i_clk);
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data  <= rc;
        @(negedge i_clk);
        i_cfg_index <= CFG_VEC_LEN;
        i_cfg_data  <= vl;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_rw  = rw;
        cur_len = int'(vl[12:0]);
        if (cur_len > VEC_DEPTH) begin
            cur_len = VEC_DEPTH;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (rows_pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic load_batch(input int count, input int span);
        repeat (count) load_entry($urandom_range(0, span - 1), rand_value());
    endtask

    // tidy rows: ascending columns, then padding; otherwise scattered columns
    task automatic gen_row(input bit tidy);
        int n;
        int s;
        int pos;
        int c;
        bit padding;
        n       = (cur_rw == 0) ? 1 : cur_rw;
        pos     = 0;
        padding = 1'b0;
        for (s = 0; s < n; s++) begin
            if ($urandom_range(0, 11) == 0) begin
                load_entry($urandom_range(0, VEC_DEPTH - 1), rand_value());
            end
            if (!tidy) begin
                send_slot(any_col(), rand_value());
            end else begin
                c = padding ? -1 : first_loaded(pos + $urandom_range(0, 2));
                if (c >= 0 && $urandom_range(0, 5) != 0) begin
                    send_slot(16'(c), rand_value());
                    pos = c + 1;
                end else begin
                    padding = 1'b1;
                    if (pos > 0 && $urandom_range(0, 3) == 0) begin
                        send_slot(16'(pos - 1), 32'h0);
                    end else begin
                        send_slot(16'($urandom_range(cur_len, 65535)),
                                  ($urandom_range(0, 3) == 0) ? $urandom : 32'h0);
                    end
                end
            end
        end
    endtask

    task automatic run_rows(input int target);
        while (n_items < target) gen_row($urandom_range(0, 99) < 80);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ROW_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_command     = CMD_LOAD;
        i_vec_index   = '0;
        i_vec_value   = '0;
        i_col_index   = '0;
        i_entry_value = '0;
        i_out_ready   = 1'b0;
        send_idle     = 12;
        recv_idle     = 74;
        hold_req      = 0;
        hold_left     = 0;
        n_items       = 0;
        cur_rw        = 1;
        cur_len       = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_regs(16'd4, 16'd3, 16'd6);
        load_entry(0, 32'h8000_0000);
        load_entry(1, 32'h8000_0000);
        load_entry(2, 32'h8000_0000);
        load_entry(3, 32'h7FFF_FFFF);
        load_entry(4, 32'hFFFF_FFFF);
        load_entry(5, 32'h0000_0001);
        load_entry(VEC_DEPTH - 1, 32'h7FFF_FFFF);
        // accumulator overflows upward
        send_slot(16'd0, 32'h8000_0000);
        send_slot(16'd1, 32'h8000_0000);
        send_slot(16'd2, 32'h8000_0000);
        send_slot(16'd3, 32'h7FFF_FFFF);
        // accumulator overflows downward
        send_slot(16'd0, 32'h7FFF_FFFF);
        send_slot(16'd1, 32'h7FFF_FFFF);
        send_slot(16'd2, 32'h7FFF_FFFF);
        send_slot(16'd3, 32'h8000_0000);
        // half-lsb tie, load mid-row, skipped column, row end, dropped slot
        send_slot(16'd4, 32'h0000_8000);
        load_entry(5, 32'h0001_0000);
        send_slot(16'd2, 32'h7FFF_FFFF);
        send_slot(16'hFFFF, 32'h1234_5678);
        send_slot(16'd5, 32'h7FFF_FFFF);
        drain();

        write_regs(16'd3, 16'd5, 16'd256);
        load_batch(80, 256);
        run_rows(650);
        drain();

        write_regs(16'd1, 16'd0, 16'd0);
        run_rows(720);
        drain();

        write_regs(16'd0, 16'd65535, 16'd8191);
        load_batch(100, VEC_DEPTH);
        run_rows(900);
        drain();

        send_idle = 74;
        recv_idle = 12;
        // long row left open, then cut short by a narrower width
        write_regs(16'd65535, 16'd65535, 16'd4096);
        repeat (12) send_slot(any_col(), rand_value());
        drain();
        write_regs(16'd2, 16'd7, 16'd4096);
        run_rows(1000);
        drain();

        write_regs(16'd16, 16'd2, 16'd4096);
        load_batch(60, VEC_DEPTH);
        run_rows(1350);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_regs(16'd2, 16'd4, 16'd100);
        load_batch(40, 100);
        hold_req = 1;
        run_rows(1900);
        drain();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
